// ----- hdl/wtrr_pkg.sv -----
package wtrr_pkg;

   localparam int TABLE_DEPTH_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 48;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   localparam int REQ_BITS         = 2;
   localparam int IN_ADDRESS_BITS  = 48;
   localparam int STATUS_BITS      = 3;
   localparam int SLOT_BITS        = 4;
   localparam int OUT_ADDRESS_BITS = 48;
   localparam int COUNT_BITS       = 5;
   localparam int COUNTER_BITS     = 32;

   localparam logic [REQ_BITS-1:0] REQ_REGISTER   = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_DEREGISTER = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_DISPATCH   = 2'd2;

   typedef enum logic [1:0] {
      OP_REGISTER,
      OP_DEREGISTER,
      OP_DISPATCH,
      OP_IGNORE
   } op_type;

   localparam int OP_BITS = $bits(op_type);

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DISPATCHED = 3'd0,
      ST_REGISTERED = 3'd1,
      ST_FULL       = 3'd2,
      ST_REMOVED    = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_NO_WORKER  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MATCH,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [REQ_BITS-1:0]        req_type;
      logic [IN_ADDRESS_BITS-1:0] worker_address;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]      status;
      logic [SLOT_BITS-1:0]        slot_index;
      logic [OUT_ADDRESS_BITS-1:0] dest_address;
      logic [COUNT_BITS-1:0]       slot_count;
   } rsp_payload_type;

endpackage

// ----- hdl/worker_table_round_robin_dispatch.sv -----
// Channel   Ports                              Direction  Beat
// request   req_valid req_stall req_payload    in         request type and worker address
// result    rsp_valid rsp_stall rsp_payload    out        status, slot, destination, count
//
// The back end handles each request in two steps: one compares the key against every live
// entry and one commits the update and loads the result register once the result is free.
// It takes the next queued request in the step that commits the current one.
// Reset clears the entry count, the round-robin pointer, the queue and both handshakes.
// A stalled result holds the back end, and the two-entry queue keeps accepting until full.
module worker_table_round_robin_dispatch #(
   parameter int TABLE_DEPTH  = wtrr_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ADDRESS_BITS = wtrr_pkg::ADDRESS_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = wtrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  wtrr_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wtrr_pkg::rsp_payload_type rsp_payload
);
   import wtrr_pkg::*;

   localparam int CMD_BITS = OP_BITS + ADDRESS_BITS;

   logic                q_push;
   logic [CMD_BITS-1:0] q_push_data;
   logic                q_full;
   logic                q_pop;
   logic [CMD_BITS-1:0] q_pop_data;
   logic                q_not_empty;

   wtrr_front #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   wtrr_queue #(
      .DATA_BITS(CMD_BITS),
      .DEPTH    (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .not_empty(q_not_empty)
   );

   wtrr_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

// ----- hdl/wtrr_front.sv -----
module wtrr_front #(
   parameter int ADDRESS_BITS = wtrr_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  wtrr_pkg::req_payload_type                      req_payload,
   input  logic                                           q_full,
   output logic                                           q_push,
   output logic [wtrr_pkg::OP_BITS+ADDRESS_BITS-1:0]      q_data
);
   import wtrr_pkg::*;

   op_type op;

   always_comb begin
      case (req_payload.req_type)
         REQ_REGISTER: begin
            op = OP_REGISTER;
         end
         REQ_DEREGISTER: begin
            op = OP_DEREGISTER;
         end
         REQ_DISPATCH: begin
            op = OP_DISPATCH;
         end
         default: begin
            op = OP_IGNORE;
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = {op, ADDRESS_BITS'(req_payload.worker_address)};

endmodule

// ----- hdl/wtrr_queue.sv -----
module wtrr_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = wtrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 not_empty
);
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]  LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(DEPTH);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FULL_FILL);
   assign not_empty = (fill_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("Queue read while empty.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("Queue fill level out of range.");

endmodule

// ----- hdl/wtrr_back.sv -----
module wtrr_back #(
   parameter int TABLE_DEPTH  = wtrr_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ADDRESS_BITS = wtrr_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      q_valid,
   input  logic [wtrr_pkg::OP_BITS+ADDRESS_BITS-1:0] q_data,
   output logic                                      q_pop,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output wtrr_pkg::rsp_payload_type                 rsp_payload
);
   import wtrr_pkg::*;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_DEPTH);

   back_state_type          state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [ADDRESS_BITS-1:0] key_ff, key_in;
   logic [TABLE_DEPTH-1:0]  hit_ff, hit_in;
   logic [ADDRESS_BITS-1:0] addr_ff [TABLE_DEPTH];
   logic [ADDRESS_BITS-1:0] addr_in [TABLE_DEPTH];
   logic [COUNTER_BITS-1:0] ctr_ff [TABLE_DEPTH];
   logic [COUNTER_BITS-1:0] ctr_in [TABLE_DEPTH];
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [IDX_BITS-1:0]     next_ff, next_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_ff, rsp_in;

   logic                    out_free;
   logic                    commit;
   logic                    full;
   logic                    empty;
   logic                    found;
   logic [IDX_BITS-1:0]     hit_slot;
   logic [IDX_BITS-1:0]     disp_slot;
   logic [TABLE_DEPTH-1:0]  shift_en;
   logic [CNT_BITS-1:0]     disp_succ;
   logic [CNT_BITS-1:0]     count_less;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = (count_ff == FULL_COUNT);
   assign empty      = (count_ff == '0);
   assign found      = |hit_ff;
   assign disp_slot  = (CNT_BITS'(next_ff) < count_ff) ? next_ff : '0;
   assign disp_succ  = CNT_BITS'(disp_slot) + CNT_BITS'(1);
   assign count_less = count_ff - CNT_BITS'(1);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The compare stage registers one hit bit per table entry, set only for a live entry that matches.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_in[i] = (CNT_BITS'(i) < count_ff) && (addr_ff[i] == key_ff);
      end
   end

   // The lowest hit is removed, and every entry from it upward takes its upper neighbor.
   always_comb begin
      logic seen;
      seen     = 1'b0;
      hit_slot = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_slot = IDX_BITS'(i);
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         seen        = seen | hit_ff[i];
         shift_en[i] = seen;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      q_pop    = 1'b0;
      commit   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = op_type'(q_data[ADDRESS_BITS +: OP_BITS]);
               key_in   = q_data[ADDRESS_BITS-1:0];
               state_in = BK_MATCH;
            end
         end
         BK_MATCH: begin
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (out_free) begin
               commit = 1'b1;
               if (q_valid) begin
                  q_pop    = 1'b1;
                  op_in    = op_type'(q_data[ADDRESS_BITS +: OP_BITS]);
                  key_in   = q_data[ADDRESS_BITS-1:0];
                  state_in = BK_MATCH;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      next_in      = next_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         addr_in[i] = addr_ff[i];
         ctr_in[i]  = ctr_ff[i];
      end
      if (commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = ST_NO_WORKER;
         rsp_in.slot_index     = '0;
         rsp_in.dest_address   = '0;
         rsp_in.slot_count     = COUNT_BITS'(count_ff);
         case (op_ff)
            OP_REGISTER: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (CNT_BITS'(i) == count_ff) begin
                        addr_in[i] = key_ff;
                        ctr_in[i]  = '0;
                     end
                  end
                  count_in          = count_ff + CNT_BITS'(1);
                  rsp_in.status     = ST_REGISTERED;
                  rsp_in.slot_index = SLOT_BITS'(count_ff);
                  rsp_in.slot_count = COUNT_BITS'(count_ff + CNT_BITS'(1));
               end
            end
            OP_DEREGISTER: begin
               if (found) begin
                  for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                     if (shift_en[i]) begin
                        addr_in[i] = addr_ff[i+1];
                        ctr_in[i]  = ctr_ff[i+1];
                     end
                  end
                  count_in = count_less;
                  if (CNT_BITS'(next_ff) >= count_less) begin
                     next_in = '0;
                  end
                  rsp_in.status     = ST_REMOVED;
                  rsp_in.slot_index = SLOT_BITS'(hit_slot);
                  rsp_in.slot_count = COUNT_BITS'(count_less);
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            OP_DISPATCH: begin
               if (!empty) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if ((IDX_BITS'(i) == disp_slot) && (ctr_ff[i] != '1)) begin
                        ctr_in[i] = ctr_ff[i] + COUNTER_BITS'(1);
                     end
                  end
                  next_in = (disp_succ >= count_ff) ? '0 : IDX_BITS'(disp_succ);
                  rsp_in.status       = ST_DISPATCHED;
                  rsp_in.slot_index   = SLOT_BITS'(disp_slot);
                  rsp_in.dest_address = OUT_ADDRESS_BITS'(addr_ff[disp_slot]);
               end
            end
            default: begin
               rsp_in.status = ST_NO_WORKER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         addr_ff[i] <= addr_in[i];
         ctr_ff[i]  <= ctr_in[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Worker count exceeds the table depth.");

   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      (empty && (next_ff == '0)) || (CNT_BITS'(next_ff) < count_ff))
      else $error("Round-robin pointer lies past the live entries.");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Back end took an item from an empty queue.");

   a_register_grows: assert property (@(posedge clock) disable iff (reset)
      (commit && (op_ff == OP_REGISTER) && !full)
      |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("Register beat did not add one entry.");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import wtrr_pkg::*;

   localparam int TABLE_DEPTH  = TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1875;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_CYCLES = 10;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   logic [IN_ADDRESS_BITS-1:0] worker_addr_tbl [TABLE_DEPTH];
   logic [COUNTER_BITS-1:0]    dispatch_cnt [TABLE_DEPTH];
   int                         live_count;
   int                         rr_pointer;
   logic [IN_ADDRESS_BITS-1:0] address_pool [6];

   rsp_payload_type expected_outcomes [$];
   rsp_payload_type want_reply;
   int              mismatch_count;
   int              cycle_count;
   int              sender_quiet;
   int              stall_run;
   int              rsp_quiet;

   worker_table_round_robin_dispatch dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Updates the table copy for one accepted request and queues the reply it should produce.
   task automatic apply_request(input req_payload_type item);
      rsp_payload_type reply;
      int              hit;
      int              slot;
      reply = '0;
      case (op_type'(item.req_type))
         OP_REGISTER: begin
            if (live_count >= TABLE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               worker_addr_tbl[live_count] = item.worker_address;
               dispatch_cnt[live_count] = '0;
               reply.status = ST_REGISTERED;
               reply.slot_index = live_count[SLOT_BITS-1:0];
               live_count++;
            end
         end
         OP_DEREGISTER: begin
            hit = -1;
            for (int i = live_count - 1; i >= 0; i--) begin
               if (worker_addr_tbl[i] == item.worker_address) hit = i;
            end
            if (hit < 0) begin
               reply.status = ST_NOT_FOUND;
            end else begin
               for (int i = hit; i < live_count - 1; i++) begin
                  worker_addr_tbl[i] = worker_addr_tbl[i + 1];
                  dispatch_cnt[i] = dispatch_cnt[i + 1];
               end
               live_count--;
               if (rr_pointer >= live_count) rr_pointer = 0;
               reply.status = ST_REMOVED;
               reply.slot_index = hit[SLOT_BITS-1:0];
            end
         end
         OP_DISPATCH: begin
            if (live_count == 0) begin
               reply.status = ST_NO_WORKER;
            end else begin
               slot = (rr_pointer < live_count) ? rr_pointer : 0;
               if (dispatch_cnt[slot] != '1) dispatch_cnt[slot]++;
               rr_pointer = (slot + 1 >= live_count) ? 0 : slot + 1;
               reply.status = ST_DISPATCHED;
               reply.slot_index = slot[SLOT_BITS-1:0];
               reply.dest_address = worker_addr_tbl[slot];
            end
         end
         default: begin
            reply.status = ST_NO_WORKER;
         end
      endcase
      reply.slot_count = live_count[COUNT_BITS-1:0];
      expected_outcomes.push_back(reply);
   endtask

   // Called right after a rising edge; returns at the edge where the beat is taken.
   task automatic send_request(input op_type op, input logic [IN_ADDRESS_BITS-1:0] address);
      req_payload_type item;
      int              gap;
      item.req_type = op;
      item.worker_address = address;
      if (sender_quiet > 0) begin
         sender_quiet--;
         gap = 0;
      end else begin
         if ($urandom_range(99) == 0) sender_quiet = $urandom_range(20, 80);
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_request(item);
   endtask

   task automatic test_empty_table();
      send_request(OP_DISPATCH, 48'h0);
      send_request(OP_DEREGISTER, 48'h0);
      send_request(OP_IGNORE, '1);
   endtask

   // A duplicate entry, removal of the first match and the pointer wrapping past the end.
   task automatic test_pointer_wrap();
      logic [IN_ADDRESS_BITS-1:0] worker;
      worker = 48'hC0A8_0001_1F90;
      send_request(OP_REGISTER, worker);
      send_request(OP_REGISTER, worker);
      send_request(OP_DISPATCH, 48'h0);
      send_request(OP_DEREGISTER, worker);
      send_request(OP_DISPATCH, 48'h0);
      send_request(OP_DEREGISTER, worker);
   endtask

   task automatic test_full_table();
      send_request(OP_REGISTER, 48'h0);
      send_request(OP_REGISTER, '1);
      send_request(OP_REGISTER, 48'h8000_0000_0001);
      for (int i = 3; i < TABLE_DEPTH; i++) begin
         send_request(OP_REGISTER, IN_ADDRESS_BITS'({$urandom(), $urandom()}));
      end
      send_request(OP_REGISTER, 48'h5555_AAAA_5555);
   endtask

   // Every 120 items a random pick sets whether the phase favors growth or draining, so the table
   // tends to sweep between empty and full.
   task automatic test_random_traffic();
      logic [IN_ADDRESS_BITS-1:0] address;
      op_type                     op;
      int                         roll;
      bit                         grow;
      address_pool[0] = '0;
      address_pool[1] = '1;
      for (int i = 2; i < 6; i++) begin
         address_pool[i] = IN_ADDRESS_BITS'({$urandom(), $urandom()});
      end
      grow = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0) grow = 1'($urandom_range(1));
         if ($urandom_range(9) < 4) begin
            address = address_pool[$urandom_range(5)];
         end else begin
            address = IN_ADDRESS_BITS'({$urandom(), $urandom()});
         end
         roll = $urandom_range(99);
         if (roll < 3) begin
            op = OP_IGNORE;
         end else if (roll < (grow ? 45 : 20)) begin
            op = OP_REGISTER;
         end else if (roll < 60) begin
            op = OP_DEREGISTER;
            if (live_count > 0 && $urandom_range(3) != 0) begin
               address = worker_addr_tbl[$urandom_range(live_count - 1)];
            end
         end else begin
            op = OP_DISPATCH;
         end
         send_request(op, address);
      end
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want_reply = expected_outcomes.pop_front();
            compare_field("status", 64'(want_reply.status), 64'(rsp_payload.status));
            compare_field("slot_index", 64'(want_reply.slot_index),
                          64'(rsp_payload.slot_index));
            compare_field("dest_address", 64'(want_reply.dest_address),
                          64'(rsp_payload.dest_address));
            compare_field("slot_count", 64'(want_reply.slot_count),
                          64'(rsp_payload.slot_count));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_quiet > 0) begin
            rsp_quiet--;
         end else if ($urandom_range(299) == 0) begin
            rsp_quiet = $urandom_range(100, 300);
         end else if ($urandom_range(2) == 0) begin
            stall_run = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", CYCLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      live_count = 0;
      rr_pointer = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_pointer_wrap();
      test_full_table();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- worker_table_round_robin_dispatch.f -----
hdl/wtrr_pkg.sv
hdl/wtrr_front.sv
hdl/wtrr_queue.sv
hdl/wtrr_back.sv
hdl/worker_table_round_robin_dispatch.sv
bench/testbench.sv
